// ===== src/nct_pkg.sv =====
`default_nettype none

package nct_pkg;

   // Default table depth.
   localparam int NCT_ENTRIES = 16;

   // Field widths of one request and one response beat.
   localparam int NCT_FUNC_W   = 2;
   localparam int NCT_ADDR_W   = 64;
   localparam int NCT_IFACE_W  = 8;
   localparam int NCT_MAC_W    = 48;
   localparam int NCT_EXPIRY_W = 32;
   localparam int NCT_STATUS_W = 2;
   localparam int NCT_INDEX_W  = 4;

   // Stream data widths, padded to whole bytes.
   localparam int NCT_REQ_FIELDS_W = NCT_FUNC_W + 2 * NCT_ADDR_W + NCT_IFACE_W +
                                     NCT_MAC_W + NCT_EXPIRY_W;
   localparam int NCT_REQ_DATA_W   = ((NCT_REQ_FIELDS_W + 7) / 8) * 8;
   localparam int NCT_RSP_FIELDS_W = NCT_STATUS_W + NCT_INDEX_W;
   localparam int NCT_RSP_DATA_W   = ((NCT_RSP_FIELDS_W + 7) / 8) * 8;

   // Operation codes.
   localparam logic [NCT_FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [NCT_FUNC_W-1:0] FUNC_ADD    = 2'd1;
   localparam logic [NCT_FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   typedef enum logic [NCT_STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SCAN,
      CS_DRAIN,
      CS_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic [NCT_ADDR_W-1:0]  addr_hi;
      logic [NCT_ADDR_W-1:0]  addr_lo;
      logic [NCT_IFACE_W-1:0] iface;
   } key_type;

   typedef struct packed {
      key_type                 key;
      logic [NCT_MAC_W-1:0]    mac;
      logic [NCT_EXPIRY_W-1:0] expiry;
   } entry_type;

   // Table access controls from the sequencer.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic set_valid;
      logic clr_valid;
   } tbl_cmd_type;

endpackage

`default_nettype wire

// ===== src/nct_table.sv =====
`default_nettype none

module nct_table
   import nct_pkg::*;
#(
   parameter int ENTRIES = NCT_ENTRIES,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tbl_cmd_type      cmd,
   input  wire logic [IDX_W-1:0] rd_idx,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire entry_type        wr_entry,
   input  wire logic [IDX_W-1:0] vld_idx,
   output key_type               rd_key,
   output logic                  vld_bit
);

   // Entry storage: one synchronous memory, one read and one write port.
   entry_type              table_mem_ff [ENTRIES];
   key_type                rd_key_ff;
   logic [ENTRIES-1:0]     valid_ff;
   logic [ENTRIES-1:0]     valid_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         table_mem_ff[wr_idx] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_key_ff <= table_mem_ff[rd_idx].key;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.set_valid) begin
         valid_in[wr_idx] = 1'b1;
      end else if (cmd.clr_valid) begin
         valid_in[wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_key  = rd_key_ff;
   assign vld_bit = valid_ff[vld_idx];

endmodule

`default_nettype wire

// ===== src/nct_ctrl.sv =====
`default_nettype none

module nct_ctrl
   import nct_pkg::*;
#(
   parameter int ENTRIES = NCT_ENTRIES,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [NCT_FUNC_W-1:0]   start_func,
   input  wire entry_type               start_entry,
   output logic                         ready,
   output tbl_cmd_type                  tbl_cmd,
   output logic [IDX_W-1:0]             rd_idx,
   output logic [IDX_W-1:0]             wr_idx,
   output entry_type                    wr_entry,
   output logic [IDX_W-1:0]             vld_idx,
   input  wire key_type                 rd_key,
   input  wire logic                    vld_bit,
   input  wire logic                    out_free,
   output logic                         done,
   output status_type                   done_status,
   output logic [NCT_INDEX_W-1:0]       done_index
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   ctrl_state_type          state_ff, state_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        cmp_idx_ff;
   logic                    hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic                    free_found_ff, free_found_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [NCT_FUNC_W-1:0]   func_ff;
   entry_type               entry_ff;
   logic                    cmp_match;
   logic                    cmp_free;
   logic [IDX_W-1:0]        res_idx;

   // The compare stage sees the entry read in the previous cycle.
   assign cmp_match = cmp_vld_ff && vld_bit && (rd_key == entry_ff.key);
   assign cmp_free  = cmp_vld_ff && !vld_bit;

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_vld_in    = 1'b0;
      hit_found_in  = hit_found_ff | cmp_match;
      hit_idx_in    = (!hit_found_ff && cmp_match) ? cmp_idx_ff : hit_idx_ff;
      free_found_in = free_found_ff | cmp_free;
      free_idx_in   = (!free_found_ff && cmp_free) ? cmp_idx_ff : free_idx_ff;
      ready         = 1'b0;
      tbl_cmd       = '0;
      done          = 1'b0;
      done_status   = ST_NOT_FOUND;
      res_idx       = '0;

      case (state_ff)
         CS_IDLE: begin
            ready = 1'b1;
            if (start) begin
               rd_idx_in     = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = CS_SCAN;
            end
         end
         CS_SCAN: begin
            tbl_cmd.rd_en = 1'b1;
            cmp_vld_in    = 1'b1;
            rd_idx_in     = IDX_W'(rd_idx_ff + 1'b1);
            if (rd_idx_ff == LAST_IDX) begin
               state_in = CS_DRAIN;
            end
         end
         CS_DRAIN: begin
            state_in = CS_COMMIT;
         end
         CS_COMMIT: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = CS_IDLE;
               case (func_ff)
                  FUNC_LOOKUP: begin
                     if (hit_found_ff) begin
                        done_status = ST_OK;
                        res_idx     = hit_idx_ff;
                     end
                  end
                  FUNC_ADD: begin
                     if (hit_found_ff) begin
                        tbl_cmd.wr_en = 1'b1;
                        done_status   = ST_OK;
                        res_idx       = hit_idx_ff;
                     end else if (free_found_ff) begin
                        tbl_cmd.wr_en     = 1'b1;
                        tbl_cmd.set_valid = 1'b1;
                        done_status       = ST_OK;
                        res_idx           = free_idx_ff;
                     end else begin
                        done_status = ST_FULL;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (hit_found_ff) begin
                        tbl_cmd.clr_valid = 1'b1;
                        done_status       = ST_OK;
                        res_idx           = hit_idx_ff;
                     end
                  end
                  default: begin
                     done_status = ST_NOT_FOUND;
                  end
               endcase
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= CS_IDLE;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= rd_idx_ff;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      if (start && ready) begin
         func_ff  <= start_func;
         entry_ff <= start_entry;
      end
   end

   // An update rewrites the whole entry; its key equals the stored one.
   assign rd_idx     = rd_idx_ff;
   assign wr_idx     = hit_found_ff ? hit_idx_ff : free_idx_ff;
   assign wr_entry   = entry_ff;
   assign vld_idx    = cmp_idx_ff;
   assign done_index = NCT_INDEX_W'(res_idx);

endmodule

`default_nettype wire

// ===== src/neighbor_cache_table_core.sv =====
// Neighbor cache table: a fixed table of ENTRIES neighbor entries keyed by a
// 128-bit IPv6 address plus an interface number, each holding a MAC address
// and an expiry value. A request beat on the req_ channel carries a lookup,
// an add-or-update or a remove; every request produces exactly one response
// beat on the rsp_ channel with a status (ok, not found, table full) and the
// entry index that matched or was written, zero when the status is not ok.
// The entries live in one synchronous memory. The sequencer reads one entry
// per cycle, compares its key and tracks both the lowest matching entry and
// the lowest free entry, then commits at most one table change in the commit state.
// After a request beat is accepted the sequencer scans every entry, lets the
// last compare finish in a drain state and commits; the response is then
// registered. A new request is accepted only after the previous one commits,
// so the scan through the memory read port sets the request rate.
// The response sits in an output register, so the next request is accepted
// while a response still waits; if the receiver stalls, the following
// request finishes its scan and holds in the commit cycle until the output
// register frees. Reset clears all valid bits and the control state; the
// table contents are left as they are and are never used while invalid.
`default_nettype none

module neighbor_cache_table_core
   import nct_pkg::*;
#(
   parameter int ENTRIES = NCT_ENTRIES
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // func[1:0], addr_hi[65:2], addr_lo[129:66], iface[137:130],
   // mac[185:138], expiry[217:186], zero pad above
   input  wire logic [NCT_REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // status[1:0], index[5:2], zero pad above
   output logic [NCT_RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic                      req_accept;
   logic [NCT_FUNC_W-1:0]     req_func;
   entry_type                 req_entry;
   logic                      ctrl_ready;
   tbl_cmd_type               tbl_cmd;
   logic [IDX_W-1:0]          rd_idx;
   logic [IDX_W-1:0]          wr_idx;
   logic [IDX_W-1:0]          vld_idx;
   entry_type                 wr_entry;
   key_type                   rd_key;
   logic                      vld_bit;
   logic                      out_free;
   logic                      done;
   status_type                done_status;
   logic [NCT_INDEX_W-1:0]    done_index;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [NCT_STATUS_W-1:0]   rsp_status_ff;
   logic [NCT_INDEX_W-1:0]    rsp_index_ff;

   // Unpack the request beat.
   assign req_func          = req_tdata[1:0];
   assign req_entry.key.addr_hi = req_tdata[65:2];
   assign req_entry.key.addr_lo = req_tdata[129:66];
   assign req_entry.key.iface   = req_tdata[137:130];
   assign req_entry.mac     = req_tdata[185:138];
   assign req_entry.expiry  = req_tdata[217:186];

   assign req_tready = ctrl_ready;
   assign req_accept = req_tvalid && ctrl_ready;

   nct_ctrl #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .start_func  (req_func),
      .start_entry (req_entry),
      .ready       (ctrl_ready),
      .tbl_cmd     (tbl_cmd),
      .rd_idx      (rd_idx),
      .wr_idx      (wr_idx),
      .wr_entry    (wr_entry),
      .vld_idx     (vld_idx),
      .rd_key      (rd_key),
      .vld_bit     (vld_bit),
      .out_free    (out_free),
      .done        (done),
      .done_status (done_status),
      .done_index  (done_index)
   );

   nct_table #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .rd_idx   (rd_idx),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry),
      .vld_idx  (vld_idx),
      .rd_key   (rd_key),
      .vld_bit  (vld_bit)
   );

   // Output register: it is free when empty or when its beat leaves now.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_status_ff <= done_status;
         rsp_index_ff  <= done_index;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(NCT_RSP_DATA_W - NCT_RSP_FIELDS_W){1'b0}},
                        rsp_index_ff, rsp_status_ff};

endmodule

`default_nettype wire
